// ===== rtl/msa_pkg.sv =====
// Shared constants, codes and types for the multi-stack shared array.
package msa_pkg;

   localparam int NUM_STACKS = 3;
   localparam int MAX_DEPTH  = 256;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int SEL_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int MEM_DEPTH = NUM_STACKS * MAX_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int STK_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Operation that has been accepted and waits for the response register (and for read data, if it reads).
   typedef struct packed {
      logic       valid;
      logic       is_read;
      status_type status;
      logic       now_empty;
   } issue_type;

endpackage

// ===== rtl/msa_req_if.sv =====
// Request channel: operation, stack number and push value.
interface msa_req_if;
   logic                                valid;
   logic                                ready;
   logic        [msa_pkg::OP_W-1:0]     operation;
   logic        [msa_pkg::SEL_W-1:0]    stack_select;
   logic signed [msa_pkg::DATA_W-1:0]   push_value;

   modport source (output valid, operation, stack_select, push_value, input ready);
   modport sink   (input valid, operation, stack_select, push_value, output ready);
endinterface

// ===== rtl/msa_rsp_if.sv =====
// Response channel: status, value read and empty flag.
interface msa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [msa_pkg::STATUS_W-1:0] status;
   logic signed [msa_pkg::DATA_W-1:0]   read_value;
   logic                                now_empty;

   modport source (output valid, status, read_value, now_empty, input ready);
   modport sink   (input valid, status, read_value, now_empty, output ready);
endinterface

// ===== rtl/msa_csr_if.sv =====
// Configuration write channel carrying the stack capacity.
interface msa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [msa_pkg::CAP_W-1:0]       stack_capacity;

   modport source (output valid, stack_capacity, input ready);
   modport sink   (input valid, stack_capacity, output ready);
endinterface

// ===== rtl/msa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 768
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data until the next read
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/msa_ctrl.sv =====
// Stack counts, full/empty decisions and memory address generation.
module msa_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic        [msa_pkg::OP_W-1:0]    operation,
   input  logic        [msa_pkg::SEL_W-1:0]   stack_select,
   input  logic        [msa_pkg::CAP_W-1:0]   capacity,
   input  logic                               advance,
   output msa_pkg::issue_type                 issue,
   output logic                               mem_we,
   output logic                               mem_re,
   output logic        [msa_pkg::ADDR_W-1:0]  mem_addr
);

   logic [msa_pkg::CNT_W-1:0] counts_ff [msa_pkg::NUM_STACKS];
   msa_pkg::issue_type        issue_ff;
   msa_pkg::issue_type        issue_in;

   logic                        accept;
   logic                        sel_ok;
   logic [msa_pkg::STK_W-1:0]   idx;
   logic [msa_pkg::CNT_W-1:0]   cnt;
   logic [msa_pkg::CNT_W-1:0]   cnt_in;
   logic [msa_pkg::CNT_W-1:0]   slot;
   logic [msa_pkg::CMP_W-1:0]   eff_cap;
   logic                        full;
   logic                        do_write;
   logic                        do_read;
   msa_pkg::status_type         status;
   msa_pkg::op_type             op;

   assign req_ready = !issue_ff.valid || advance;
   assign accept    = req_valid && req_ready;
   assign op        = msa_pkg::op_type'(operation);
   assign sel_ok    = int'(stack_select) < msa_pkg::NUM_STACKS;
   assign idx       = msa_pkg::STK_W'(stack_select);
   assign cnt       = sel_ok ? counts_ff[idx] : '0;

   // saturate capacity into 1..MAX_DEPTH
   always_comb begin
      if (capacity == '0) begin
         eff_cap = msa_pkg::CMP_W'(1);
      end else if (msa_pkg::CMP_W'(capacity) > msa_pkg::CMP_W'(msa_pkg::MAX_DEPTH)) begin
         eff_cap = msa_pkg::CMP_W'(msa_pkg::MAX_DEPTH);
      end else begin
         eff_cap = msa_pkg::CMP_W'(capacity);
      end
   end

   assign full = msa_pkg::CMP_W'(cnt) >= eff_cap;

   always_comb begin
      status   = msa_pkg::ST_OK;
      cnt_in   = cnt;
      slot     = cnt;
      do_write = 1'b0;
      do_read  = 1'b0;
      if (sel_ok) begin
         unique case (op)
            msa_pkg::OP_PUSH: begin
               if (full) begin
                  status = msa_pkg::ST_FULL;
               end else begin
                  do_write = 1'b1;
                  cnt_in   = cnt + msa_pkg::CNT_W'(1);
               end
            end
            msa_pkg::OP_POP, msa_pkg::OP_PEEK: begin
               if (cnt == '0) begin
                  status = msa_pkg::ST_EMPTY;
               end else begin
                  do_read = 1'b1;
                  slot    = cnt - msa_pkg::CNT_W'(1);
                  if (op == msa_pkg::OP_POP) begin
                     cnt_in = cnt - msa_pkg::CNT_W'(1);
                  end
               end
            end
            msa_pkg::OP_QUERY: begin
            end
         endcase
      end else begin
         unique case (op)
            msa_pkg::OP_PUSH:                  status = msa_pkg::ST_FULL;
            msa_pkg::OP_POP, msa_pkg::OP_PEEK: status = msa_pkg::ST_EMPTY;
            msa_pkg::OP_QUERY:                 status = msa_pkg::ST_OK;
         endcase
      end
   end

   // partitions sit at a fixed stride of MAX_DEPTH
   assign mem_addr = msa_pkg::ADDR_W'(idx) * msa_pkg::ADDR_W'(msa_pkg::MAX_DEPTH)
                   + msa_pkg::ADDR_W'(slot);
   assign mem_we   = accept && do_write;
   assign mem_re   = accept && do_read;

   always_comb begin
      issue_in.valid     = accept;
      issue_in.is_read   = do_read;
      issue_in.status    = status;
      issue_in.now_empty = (cnt_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msa_pkg::NUM_STACKS; i++) begin
            counts_ff[i] <= '0;
         end
         issue_ff <= '0;
      end else begin
         if (accept && sel_ok) begin
            counts_ff[idx] <= cnt_in;
         end
         if (req_ready) begin
            issue_ff <= issue_in;
         end
      end
   end

   assign issue = issue_ff;

endmodule

// ===== rtl/multi_stack_shared_array_top.sv =====
// Top level of the multi-stack shared array.
// NUM_STACKS LIFO stacks share one element RAM cut into fixed partitions of
// MAX_DEPTH words. The block accepts one operation per cycle while the response
// channel does not stall it, and answers each with one response through the issue
// register and the response register: the first decides the outcome from the
// per-stack counts and issues at most one RAM access (write for push, read for
// pop or peek), the second takes the registered RAM read data. A push is written
// before any later read is issued, so no forwarding is needed. Backpressure on
// the response channel stalls the request channel once both stages are full.
// The capacity register may be written at any time the block is idle; values
// outside 1..MAX_DEPTH are saturated into that range.
module multi_stack_shared_array_top (
   input logic        clock,
   input logic        reset,
   msa_req_if.sink    req_if,
   msa_rsp_if.source  rsp_if,
   msa_csr_if.sink    csr_if
);

   logic [msa_pkg::CAP_W-1:0]    cap_ff;
   msa_pkg::issue_type           issue;
   logic                         advance;
   logic                         mem_we;
   logic                         mem_re;
   logic [msa_pkg::ADDR_W-1:0]   mem_addr;
   logic [msa_pkg::DATA_W-1:0]   mem_rdata;

   logic                         rsp_valid_ff;
   logic [msa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [msa_pkg::DATA_W-1:0]   rsp_value_ff;
   logic                         rsp_empty_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= msa_pkg::CAP_RESET;
      end else if (csr_if.valid) begin
         cap_ff <= csr_if.stack_capacity;
      end
   end

   msa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .operation    (req_if.operation),
      .stack_select (req_if.stack_select),
      .capacity     (cap_ff),
      .advance      (advance),
      .issue        (issue),
      .mem_we       (mem_we),
      .mem_re       (mem_re),
      .mem_addr     (mem_addr)
   );

   msa_ram #(
      .WIDTH (msa_pkg::DATA_W),
      .DEPTH (msa_pkg::MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_addr),
      .wdata (req_if.push_value),
      .re    (mem_re),
      .raddr (mem_addr),
      .rdata (mem_rdata)
   );

   // advance the response register when it is empty or its transfer completes
   assign advance = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= issue.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= issue.status;
         rsp_value_ff  <= issue.is_read ? mem_rdata : '0;
         rsp_empty_ff  <= issue.now_empty;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.read_value = rsp_value_ff;
   assign rsp_if.now_empty  = rsp_empty_ff;

endmodule

// ===== rtl/msa_checker.sv =====
// Port-level checks for the multi-stack shared array, bound to the top level.
module msa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic        [msa_pkg::STATUS_W-1:0] rsp_status,
   input logic        [msa_pkg::DATA_W-1:0]   rsp_read_value,
   input logic                               rsp_now_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_now_empty))
      else $error("response dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == msa_pkg::ST_OK || rsp_status == msa_pkg::ST_FULL
         || rsp_status == msa_pkg::ST_EMPTY))
      else $error("undefined status code");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == msa_pkg::ST_EMPTY |-> rsp_now_empty && rsp_read_value == '0)
      else $error("empty status with data or nonempty stack");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == msa_pkg::ST_FULL |-> rsp_read_value == '0)
      else $error("refused push returned data");

endmodule

bind multi_stack_shared_array_top msa_checker u_msa_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_read_value (rsp_if.read_value),
   .rsp_now_empty  (rsp_if.now_empty)
);
